@@ sv/arp_presence_table_macros.svh @@
`ifndef ARP_PRESENCE_TABLE_MACROS_SVH
`define ARP_PRESENCE_TABLE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define APT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define APT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/apt_pkg.sv @@
`timescale 1ns / 1ps

package apt_pkg;

  localparam logic [15:0] ARP_OP_REPLY  = 16'd2;
  localparam logic [15:0] ARP_HW_ETH    = 16'd1;
  localparam logic [15:0] ARP_PROTO_IP4 = 16'h0800;
  localparam logic [10:0] ARP_FRAME_LEN = 11'd60;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int LIMIT_W    = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROBE_INTERVAL,
    CFG_TIMEOUT_ROUNDS
  } cfg_idx_e;

  typedef enum logic {
    CMD_FRAME,
    CMD_TICK
  } cmd_e;

  typedef enum logic [1:0] {
    EV_FOUND,
    EV_CHANGED,
    EV_LOST,
    EV_FULL
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_AGE,
    ST_EMIT_OLD,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] opcode;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [10:0] frame_len;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] now_seconds;
  } in_t;

  typedef struct packed {
    event_e      event_res;
    logic [31:0] host_ip;
    logic [47:0] host_mac;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    logic ip_hit;
    logic mac_same;
    logic expired;
  } unit_res_t;

  typedef struct packed {
    logic valid;
    out_t ev;
  } evt_push_t;

endpackage

@@ sv/apt_ram.sv @@
`timescale 1ns / 1ps

module apt_ram #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/apt_unit.sv @@
`timescale 1ns / 1ps

module apt_unit (
  input  apt_pkg::entry_t                entry_i,
  input  logic [31:0]                    ip_i,
  input  logic [47:0]                    mac_i,
  input  logic [31:0]                    now_i,
  input  logic [apt_pkg::LIMIT_W-1:0]    limit_i,
  output apt_pkg::unit_res_t             res_o
);

  logic [31:0] age;

  // age wraps modulo 2^32
  assign age = now_i - entry_i.seen;

  assign res_o.ip_hit   = (entry_i.ip == ip_i);
  assign res_o.mac_same = (entry_i.mac == mac_i);
  assign res_o.expired  = (age > {{(32 - apt_pkg::LIMIT_W){1'b0}}, limit_i});

endmodule

@@ sv/apt_ctrl.sv @@
`timescale 1ns / 1ps
`include "arp_presence_table_macros.svh"

module apt_ctrl #(
  parameter int TABLE_DEPTH = 32,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  apt_pkg::in_t                  in_data_i,
  output logic                          in_stall_o,
  input  logic [apt_pkg::LIMIT_W-1:0]   limit_i,
  input  logic                          slot_free_i,
  output apt_pkg::evt_push_t            push_o,
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_waddr_o,
  output apt_pkg::entry_t               ram_wdata_o,
  output logic [AW-1:0]                 ram_raddr_o,
  input  apt_pkg::entry_t               ram_rdata_i
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  apt_pkg::state_e    state_q, state_d;
  apt_pkg::in_t       item_q, item_d;
  logic [CW-1:0]      fetch_q, fetch_d;
  logic               chk_valid_q, chk_valid_d;
  logic [AW-1:0]      chk_idx_q, chk_idx_d;
  logic [CW-1:0]      wr_q, wr_d;
  logic [CW-1:0]      count_q, count_d;
  logic               pend_valid_q, pend_valid_d;
  apt_pkg::out_t      pend_q, pend_d;
  logic [47:0]        old_mac_q, old_mac_d;

  apt_pkg::unit_res_t res;
  logic               frame_ok;
  logic               fetch_more;
  logic               step;
  logic [CW-1:0]      chk_ext;

  apt_unit u_unit (
    .entry_i (ram_rdata_i),
    .ip_i    (item_q.sender_ip),
    .mac_i   (item_q.sender_mac),
    .now_i   (item_q.now_seconds),
    .limit_i (limit_i),
    .res_o   (res)
  );

  assign frame_ok = (in_data_i.opcode == apt_pkg::ARP_OP_REPLY) &&
                    (in_data_i.hw_type == apt_pkg::ARP_HW_ETH) &&
                    (in_data_i.proto_type == apt_pkg::ARP_PROTO_IP4) &&
                    (in_data_i.frame_len == apt_pkg::ARP_FRAME_LEN);

  assign fetch_more = (fetch_q < count_q);
  assign chk_ext    = CW'(chk_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= apt_pkg::ST_IDLE;
      fetch_q      <= '0;
      chk_valid_q  <= 1'b0;
      chk_idx_q    <= '0;
      wr_q         <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      fetch_q      <= fetch_d;
      chk_valid_q  <= chk_valid_d;
      chk_idx_q    <= chk_idx_d;
      wr_q         <= wr_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    pend_q    <= pend_d;
    old_mac_q <= old_mac_d;
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    fetch_d      = fetch_q;
    chk_valid_d  = chk_valid_q;
    chk_idx_d    = chk_idx_q;
    wr_d         = wr_q;
    count_d      = count_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    old_mac_d    = old_mac_q;
    in_stall_o   = 1'b1;
    push_o       = '0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = chk_idx_q;
    ram_wdata_o  = ram_rdata_i;
    ram_raddr_o  = chk_idx_q;
    step         = 1'b0;

    case (state_q)
      apt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d       = in_data_i;
          fetch_d      = '0;
          chk_valid_d  = 1'b0;
          wr_d         = '0;
          pend_valid_d = 1'b0;
          if (in_data_i.cmd == apt_pkg::CMD_TICK) begin
            state_d = apt_pkg::ST_AGE;
          end else if (frame_ok) begin
            state_d = apt_pkg::ST_LOOK;
          end
        end
      end

      apt_pkg::ST_LOOK: begin
        if (chk_valid_q && res.ip_hit) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = chk_idx_q;
          ram_wdata_o = '{ip: item_q.sender_ip, mac: item_q.sender_mac,
                          seen: item_q.now_seconds};
          chk_valid_d = 1'b0;
          if (res.mac_same) begin
            state_d = apt_pkg::ST_IDLE;
          end else begin
            pend_d       = '{event_res: apt_pkg::EV_CHANGED, host_ip: item_q.sender_ip,
                             host_mac: item_q.sender_mac, last: 1'b0};
            pend_valid_d = 1'b1;
            old_mac_d    = ram_rdata_i.mac;
            state_d      = apt_pkg::ST_EMIT_OLD;
          end
        end else if (!chk_valid_q && !fetch_more) begin
          if (count_q == DEPTH_C) begin
            pend_d = '{event_res: apt_pkg::EV_FULL, host_ip: item_q.sender_ip,
                       host_mac: item_q.sender_mac, last: 1'b0};
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = count_q[AW-1:0];
            ram_wdata_o = '{ip: item_q.sender_ip, mac: item_q.sender_mac,
                            seen: item_q.now_seconds};
            count_d     = count_q + CW'(1);
            pend_d      = '{event_res: apt_pkg::EV_FOUND, host_ip: item_q.sender_ip,
                            host_mac: item_q.sender_mac, last: 1'b0};
          end
          pend_valid_d = 1'b1;
          state_d      = apt_pkg::ST_FLUSH;
        end else begin
          step = 1'b1;
        end
      end

      apt_pkg::ST_AGE: begin
        if (!chk_valid_q && !fetch_more) begin
          count_d = wr_q;
          state_d = apt_pkg::ST_FLUSH;
        end else if (chk_valid_q && res.expired) begin
          // one lost transaction held back so the final one can carry last
          if (!pend_valid_q || slot_free_i) begin
            push_o.valid = pend_valid_q;
            push_o.ev    = pend_q;
            pend_d       = '{event_res: apt_pkg::EV_LOST, host_ip: ram_rdata_i.ip,
                             host_mac: ram_rdata_i.mac, last: 1'b0};
            pend_valid_d = 1'b1;
            step         = 1'b1;
          end
        end else begin
          if (chk_valid_q) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = wr_q[AW-1:0];
            ram_wdata_o = ram_rdata_i;
            wr_d        = wr_q + CW'(1);
          end
          step = 1'b1;
        end
      end

      apt_pkg::ST_EMIT_OLD: begin
        if (slot_free_i) begin
          push_o.valid = 1'b1;
          push_o.ev    = pend_q;
          pend_d       = '{event_res: apt_pkg::EV_LOST, host_ip: item_q.sender_ip,
                           host_mac: old_mac_q, last: 1'b0};
          state_d      = apt_pkg::ST_FLUSH;
        end
      end

      apt_pkg::ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = apt_pkg::ST_IDLE;
        end else if (slot_free_i) begin
          push_o.valid   = 1'b1;
          push_o.ev      = pend_q;
          push_o.ev.last = 1'b1;
          pend_valid_d   = 1'b0;
          state_d        = apt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = apt_pkg::ST_IDLE;
      end
    endcase

    // table walk: issue next read, or re-read the held entry
    if (step) begin
      ram_raddr_o = fetch_q[AW-1:0];
      if (fetch_more) begin
        chk_valid_d = 1'b1;
        chk_idx_d   = fetch_q[AW-1:0];
        fetch_d     = fetch_q + CW'(1);
      end else begin
        chk_valid_d = 1'b0;
      end
    end
  end

  `APT_ASSERT(a_count_range, clk_i, rst_ni, count_q <= DEPTH_C, "entry count above table depth")
  `APT_ASSERT(a_push_slot, clk_i, rst_ni, !push_o.valid || slot_free_i, "push into busy output")
  `APT_ASSERT(a_chk_in_table, clk_i, rst_ni, !chk_valid_q || (chk_ext < count_q), "walk beyond count")
  `APT_ASSERT(a_compact_order, clk_i, rst_ni, (state_q != apt_pkg::ST_AGE) || (wr_q <= fetch_q), "compaction write ahead of read")
  `APT_ASSERT_NEXT(a_age_count, clk_i, rst_ni, (state_q == apt_pkg::ST_AGE) && !chk_valid_q && !fetch_more, count_q == $past(wr_q), "count not set from compaction")

endmodule

@@ sv/arp_presence_table.sv @@
// The walk reads the entry RAM one entry per cycle through its single read port, unless an
// aged-out entry is held waiting for a free output slot.
// Throughput: one item at a time; in_stall_o stays high from acceptance until the last
// transaction of the item, if any, is in the output register.
// Reset: entry count cleared, probe_interval 10, timeout_rounds 3; entry RAM not cleared.
`timescale 1ns / 1ps

module arp_presence_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  apt_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output apt_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [apt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [apt_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [11:0]                 probe_q;
  logic [7:0]                  rounds_q;
  logic [apt_pkg::LIMIT_W-1:0] limit_q;
  logic                        out_valid_q;
  apt_pkg::out_t               out_q;

  apt_pkg::evt_push_t push;
  logic               slot_free;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  apt_pkg::entry_t    ram_wdata;
  apt_pkg::entry_t    ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q  <= 12'd10;
      rounds_q <= 8'd3;
      limit_q  <= apt_pkg::LIMIT_W'(30);
    end else begin
      if (cfg_we_i) begin
        case (apt_pkg::cfg_idx_e'(cfg_idx_i))
          apt_pkg::CFG_PROBE_INTERVAL: probe_q  <= cfg_data_i;
          apt_pkg::CFG_TIMEOUT_ROUNDS: rounds_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      limit_q <= {8'b0, probe_q} * {12'b0, rounds_q};
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_q <= push.ev;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  apt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .limit_i     (limit_q),
    .slot_free_i (slot_free),
    .push_o      (push),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  apt_ram #(
    .WIDTH ($bits(apt_pkg::entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
